>>> design/assert_macros.svh
// Assertion helpers for the prior box generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define PBG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PBG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/pbg_pkg.sv
// ----------------------------------------------------------------------------
// pbg_pkg
// Types and constants of the prior box generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbg_pkg;

    localparam int CFG_W    = 48;
    localparam int ADDR_W   = 4;
    localparam int SIZE_W   = 12;
    localparam int SLOT_W   = 3;
    localparam int COORD_W  = 16;
    localparam int IDX_W    = 10;
    localparam int CEN_W    = 34;
    localparam int NUM_W    = 40;
    localparam int DIM_W    = 13;
    localparam int DVS_W    = 14;
    localparam int NP_W     = 30;
    localparam int ROOT_W   = 24;
    localparam int RAD_W    = 48;
    localparam int REM_W    = 26;
    localparam int SQ_STG   = 6;
    localparam int SQ_STEP  = 4;
    localparam int DIV_STG  = 4;
    localparam int DIV_STEP = 4;

    // Register indexes
    localparam logic [ADDR_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [ADDR_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;
    localparam logic [ADDR_W-1:0] CFG_STEP_X       = 4'd2;
    localparam logic [ADDR_W-1:0] CFG_STEP_Y       = 4'd3;
    localparam logic [ADDR_W-1:0] CFG_CELL_OFFSET  = 4'd4;
    localparam logic [ADDR_W-1:0] CFG_CLIP_ENABLE  = 4'd5;
    localparam logic [ADDR_W-1:0] CFG_MIN_TABLE    = 4'd6;
    localparam logic [ADDR_W-1:0] CFG_MAX_TABLE    = 4'd7;

    localparam logic [DIM_W-1:0] RST_IMAGE_DIM   = 13'd300;
    localparam logic [15:0]      RST_STEP        = 16'd128;
    localparam logic [7:0]       RST_CELL_OFFSET = 8'd128;

    localparam logic signed [COORD_W-1:0] COORD_MAX  = 16'sd32767;
    localparam logic signed [COORD_W-1:0] COORD_MIN  = -16'sd32768;
    localparam logic signed [COORD_W-1:0] COORD_ONE  = 16'sd16384;
    localparam logic signed [COORD_W-1:0] COORD_ZERO = 16'sd0;

    typedef struct packed {
        logic [CEN_W-1:0]  cx;
        logic [CEN_W-1:0]  cy;
        logic [SIZE_W-1:0] mn;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_side;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_tag;

endpackage

`default_nettype wire

>>> design/pbg_isqrt.sv
// ----------------------------------------------------------------------------
// pbg_isqrt
// Pipelined integer square root of (p << 24), four root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_isqrt (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire  [pbg_pkg::ROOT_W-1:0]  i_prod,
    output logic [pbg_pkg::ROOT_W-1:0]  o_root
);
    import pbg_pkg::*;

    logic [REM_W-1:0]  r_rem  [SQ_STG];
    logic [ROOT_W-1:0] r_root [SQ_STG];
    logic [RAD_W-1:0]  r_rad  [SQ_STG];

    for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
        logic [REM_W-1:0]  src_rem, n_rem;
        logic [ROOT_W-1:0] src_root, n_root;
        logic [RAD_W-1:0]  src_rad, n_rad;
        logic [REM_W+1:0]  t, trial;

        if (g == 0) begin : g_src0
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_rad  = {i_prod, {ROOT_W{1'b0}}};
        end else begin : g_srcn
            assign src_rem  = r_rem[g-1];
            assign src_root = r_root[g-1];
            assign src_rad  = r_rad[g-1];
        end

        always_comb begin
            n_rem  = src_rem;
            n_root = src_root;
            n_rad  = src_rad;
            t      = '0;
            trial  = '0;
            for (int k = 0; k < SQ_STEP; k++) begin
                t     = {n_rem, n_rad[RAD_W-1 -: 2]};
                trial = (REM_W+2)'({n_root, 2'b01});
                if (t >= trial) begin
                    n_rem  = REM_W'(t - trial);
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = REM_W'(t);
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
                n_rad = n_rad << 2;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= n_rad;
            end
        end
    end

    assign o_root = r_root[SQ_STG-1];

endmodule

`default_nettype wire

>>> design/pbg_norm.sv
// ----------------------------------------------------------------------------
// pbg_norm
// Rounded, saturated, optionally clipped quotient of an edge numerator.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_norm (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire  signed [pbg_pkg::NUM_W-1:0]    i_num,
    input  wire         [pbg_pkg::DVS_W-1:0]    i_dvs,
    input  wire                                 i_clip,
    output logic signed [pbg_pkg::COORD_W-1:0]  o_coord
);
    import pbg_pkg::*;

    localparam int LIM_W = DVS_W + COORD_W - 1;

    logic signed [NUM_W-1:0] lim;
    logic signed [NUM_W-1:0] n_np;
    logic                    r_hi  [DIV_STG+1];
    logic                    r_lo  [DIV_STG+1];
    logic [DVS_W-1:0]        r_rem [DIV_STG+1];
    logic [COORD_W-1:0]      r_bits[DIV_STG+1];
    logic [COORD_W-1:0]      r_quo [DIV_STG+1];
    logic signed [COORD_W-1:0] n_coord;
    logic signed [COORD_W-1:0] r_coord;

    // Bias by 32768 divisors so the quotient becomes unsigned 16 bits
    assign lim  = signed'(NUM_W'({i_dvs, {(LIM_W-DVS_W){1'b0}}}));
    assign n_np = i_num + lim;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi[0]   <= i_num >= lim;
            r_lo[0]   <= i_num < -lim;
            r_rem[0]  <= n_np[NP_W-1 -: DVS_W];
            r_bits[0] <= n_np[COORD_W-1:0];
            r_quo[0]  <= '0;
        end
    end

    for (genvar g = 1; g <= DIV_STG; g++) begin : g_div
        logic [DVS_W-1:0]   n_rem;
        logic [COORD_W-1:0] n_bits, n_quo;
        logic [DVS_W:0]     t;

        always_comb begin
            n_rem  = r_rem[g-1];
            n_bits = r_bits[g-1];
            n_quo  = r_quo[g-1];
            t      = '0;
            for (int k = 0; k < DIV_STEP; k++) begin
                t = {n_rem, n_bits[COORD_W-1]};
                if (t >= {1'b0, i_dvs}) begin
                    n_rem = DVS_W'(t - {1'b0, i_dvs});
                    n_quo = {n_quo[COORD_W-2:0], 1'b1};
                end else begin
                    n_rem = DVS_W'(t);
                    n_quo = {n_quo[COORD_W-2:0], 1'b0};
                end
                n_bits = n_bits << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hi[g]   <= r_hi[g-1];
                r_lo[g]   <= r_lo[g-1];
                r_rem[g]  <= n_rem;
                r_bits[g] <= n_bits;
                r_quo[g]  <= n_quo;
            end
        end
    end

    always_comb begin
        priority if (r_hi[DIV_STG]) begin
            n_coord = COORD_MAX;
        end else if (r_lo[DIV_STG]) begin
            n_coord = COORD_MIN;
        end else begin
            n_coord = signed'({~r_quo[DIV_STG][COORD_W-1], r_quo[DIV_STG][COORD_W-2:0]});
        end
        // clamp to 0 .. 1, leave in-range values untouched
        if (i_clip) begin
            if (n_coord < COORD_ZERO) begin
                n_coord = COORD_ZERO;
            end else if (n_coord > COORD_ONE) begin
                n_coord = COORD_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

`default_nettype wire

>>> design/prior_box_generator_top.sv
// ----------------------------------------------------------------------------
// prior_box_generator_top
// Anchor box generator: one feature-map cell in, 2*NUM_SIZES boxes out.
// ----------------------------------------------------------------------------
// Throughput: one box per cycle while the output does not stall; the input
//   sequencer that expands a cell into its boxes sets this rate.
// Any output stall freezes the whole pipeline for that cycle.
// Reset (synchronous, active low) empties the pipeline and loads the
//   register defaults; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module prior_box_generator_top #(
    parameter int NUM_SIZES = 1
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration write port
    input  wire                             i_cfg_we,
    input  wire  [pbg_pkg::ADDR_W-1:0]      i_cfg_addr,
    input  wire  [pbg_pkg::CFG_W-1:0]       i_cfg_wdata,
    // cell stream
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [23:0]                     s_axis_tdata,   // cell_col, cell_row, pad
    // box stream
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [63:0]                     m_axis_tdata,   // xmin, ymin, xmax, ymax
    output logic [pbg_pkg::SLOT_W-1:0]      m_axis_tuser,   // prior_slot
    output logic                            m_axis_tlast    // last_prior
);
    import pbg_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(2 * NUM_SIZES - 1);
    localparam int NUM_STG  = SQ_STG + 1;           // r_vld bit of the numerator stage
    localparam int OUT_STG  = NUM_STG + DIV_STG + 2; // r_vld bit of the output register
    localparam int VLD_W    = OUT_STG + 1;

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0]       r_img_w, r_img_h;
    logic [15:0]            r_step_x, r_step_y;
    logic [7:0]             r_offset;
    logic                   r_clip;
    logic [4*SIZE_W-1:0]    r_min_tab, r_max_tab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= RST_IMAGE_DIM;
            r_img_h   <= RST_IMAGE_DIM;
            r_step_x  <= RST_STEP;
            r_step_y  <= RST_STEP;
            r_offset  <= RST_CELL_OFFSET;
            r_clip    <= 1'b0;
            r_min_tab <= '0;
            r_max_tab <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_WIDTH:  r_img_w   <= i_cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_img_h   <= i_cfg_wdata[DIM_W-1:0];
                CFG_STEP_X:       r_step_x  <= i_cfg_wdata[15:0];
                CFG_STEP_Y:       r_step_y  <= i_cfg_wdata[15:0];
                CFG_CELL_OFFSET:  r_offset  <= i_cfg_wdata[7:0];
                CFG_CLIP_ENABLE:  r_clip    <= i_cfg_wdata[0];
                CFG_MIN_TABLE:    r_min_tab <= i_cfg_wdata;
                CFG_MAX_TABLE:    r_max_tab <= i_cfg_wdata;
                default: ;        // drop writes beyond the register list
            endcase
        end
    end

    // Zero dimension behaves as one; divisor is twice the dimension
    logic [DIM_W-1:0] dim_w, dim_h;
    logic [DVS_W-1:0] dvs_w, dvs_h;
    assign dim_w = (r_img_w == '0) ? DIM_W'(1) : r_img_w;
    assign dim_h = (r_img_h == '0) ? DIM_W'(1) : r_img_h;
    assign dvs_w = {dim_w, 1'b0};
    assign dvs_h = {dim_h, 1'b0};

    // ---------------- pipeline control ----------------
    // Advance every stage together unless the output holds an untaken box.
    logic                ce;
    logic [VLD_W-1:0]    r_vld;   // bit i: pipeline slot i+1 holds a box
    assign ce = !r_vld[OUT_STG] || m_axis_tready;

    // Stage 0: sequencer, holds the cell and steps through its prior slots
    logic                r_hv;
    logic [IDX_W-1:0]    r_col, r_row;
    logic [SLOT_W-1:0]   r_cnt;

    assign s_axis_tready = ce && (!r_hv || r_cnt == LAST_SLOT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_cnt <= '0;
        end else if (ce) begin
            if (r_hv && r_cnt != LAST_SLOT) begin
                r_cnt <= r_cnt + SLOT_W'(1);
            end else begin
                r_hv  <= s_axis_tvalid;
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_col <= s_axis_tdata[IDX_W-1:0];
            r_row <= s_axis_tdata[2*IDX_W-1:IDX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[VLD_W-2:0], r_hv};
        end
    end

    // Stage 1: cell centres and size product
    logic [1:0]          entry;
    logic [SIZE_W-1:0]   sel_mn, sel_mx;
    t_side               n_s1, r_s1;
    logic [ROOT_W-1:0]   r_prod;

    assign entry  = r_cnt[SLOT_W-1:1];
    assign sel_mn = r_min_tab[SIZE_W*entry +: SIZE_W];
    assign sel_mx = r_max_tab[SIZE_W*entry +: SIZE_W];

    always_comb begin
        n_s1.cx   = CEN_W'({r_col, r_offset} * r_step_x);
        n_s1.cy   = CEN_W'({r_row, r_offset} * r_step_y);
        n_s1.mn   = sel_mn;
        n_s1.slot = r_cnt;
        n_s1.last = (r_cnt == LAST_SLOT);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s1   <= n_s1;
            r_prod <= sel_mn * sel_mx;
        end
    end

    // Stages 2..7: geometric-mean side, sideband held alongside
    logic [ROOT_W-1:0]   root;
    t_side               r_dly [SQ_STG];

    pbg_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (ce),
        .i_prod (r_prod),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dly[0] <= r_s1;
            for (int i = 1; i < SQ_STG; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // Stage 8: edge numerators 4*(2C -/+ S) + D
    t_side                   sd;
    logic [ROOT_W-1:0]       side;
    logic signed [NUM_W-1:0] c8x, c8y, s4, dw, dh;
    logic signed [NUM_W-1:0] r_nxl, r_nyl, r_nxh, r_nyh;
    t_tag                    r_ntag;

    assign sd   = r_dly[SQ_STG-1];
    assign side = sd.slot[0] ? root : {sd.mn, {(ROOT_W-SIZE_W){1'b0}}};
    assign c8x  = signed'(NUM_W'({sd.cx, 3'b000}));
    assign c8y  = signed'(NUM_W'({sd.cy, 3'b000}));
    assign s4   = signed'(NUM_W'({side, 2'b00}));
    assign dw   = signed'(NUM_W'(dim_w));
    assign dh   = signed'(NUM_W'(dim_h));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_nxl  <= c8x - s4 + dw;
            r_nyl  <= c8y - s4 + dh;
            r_nxh  <= c8x + s4 + dw;
            r_nyh  <= c8y + s4 + dh;
            r_ntag <= '{slot: sd.slot, last: sd.last};
        end
    end

    // Stages 9..14: divide, saturate, clip and register the four corners
    logic signed [COORD_W-1:0] xmin, ymin, xmax, ymax;
    t_tag                      r_tag [DIV_STG+2];

    pbg_norm u_norm_xl (.i_clk(i_clk), .i_en(ce), .i_num(r_nxl), .i_dvs(dvs_w),
                        .i_clip(r_clip), .o_coord(xmin));
    pbg_norm u_norm_yl (.i_clk(i_clk), .i_en(ce), .i_num(r_nyl), .i_dvs(dvs_h),
                        .i_clip(r_clip), .o_coord(ymin));
    pbg_norm u_norm_xh (.i_clk(i_clk), .i_en(ce), .i_num(r_nxh), .i_dvs(dvs_w),
                        .i_clip(r_clip), .o_coord(xmax));
    pbg_norm u_norm_yh (.i_clk(i_clk), .i_en(ce), .i_num(r_nyh), .i_dvs(dvs_h),
                        .i_clip(r_clip), .o_coord(ymax));

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_tag[0] <= r_ntag;
            for (int i = 1; i < DIV_STG + 2; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    assign m_axis_tvalid = r_vld[OUT_STG];
    assign m_axis_tdata  = {ymax, xmax, ymin, xmin};
    assign m_axis_tuser  = r_tag[DIV_STG+1].slot;
    assign m_axis_tlast  = r_tag[DIV_STG+1].last;

    // ---------------- checks ----------------
    `PBG_ASSERT(a_last_on_final_slot, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == LAST_SLOT, "last_prior away from the final slot")
    `PBG_ASSERT(a_take_only_when_moving, s_axis_tready |-> (!m_axis_tvalid || m_axis_tready), "cell taken while the pipeline is stalled")
    `PBG_ASSERT(a_seq_slot_range, r_hv |-> r_cnt <= LAST_SLOT, "sequencer slot beyond the last prior")
    `PBG_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !m_axis_tvalid && !r_hv, "pipeline not empty after reset")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for prior_box_generator_top: cells go in on the slave
// stream, boxes are predicted in the bench and compared field by field as
// they come out of the master stream, under random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pbg_pkg::*;

    localparam int  N_SIZES   = 1;
    localparam int  WATCHDOG  = 20000;
    localparam int  DRAIN     = 40;
    localparam int  N_RANDOM  = 480;
    localparam int  HOLD_LEN  = 300;

    // index past the register list, writes to it are dropped
    localparam logic [ADDR_W-1:0] CFG_UNMAPPED = 4'd9;

    typedef struct packed {
        logic signed [15:0] xmin;
        logic signed [15:0] ymin;
        logic signed [15:0] xmax;
        logic signed [15:0] ymax;
        logic [2:0]         slot;
        logic               last;
    } t_box;

    // directed row: a cell, plus an optional typed-in first box
    typedef struct {
        logic [9:0] col;
        logic [9:0] row;
        bit         typed;
        t_box       box;
    } t_cell_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    wire               s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;
    wire               m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    wire  [63:0]       m_axis_tdata;
    wire  [SLOT_W-1:0] m_axis_tuser;
    wire               m_axis_tlast;

    prior_box_generator_top #(.NUM_SIZES(N_SIZES)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the register file
    logic [12:0] img_w, img_h;
    logic [15:0] stp_x, stp_y;
    logic [7:0]  cen_off;
    logic        clip_on;
    logic [47:0] min_tab, max_tab;

    t_box pending_boxes[$];
    int   failures = 0;
    int   idle_cycles = 0;
    bit   hold_off = 0;

    task automatic shadow_reset();
        img_w = 300; img_h = 300; stp_x = 128; stp_y = 128;
        cen_off = 128; clip_on = 0; min_tab = '0; max_tab = '0;
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // edge in 2^-13 pixel to Q2.14, rounded half up, saturated, optionally clipped
    function automatic logic signed [15:0] to_norm(longint e, logic [12:0] dim);
        longint d, n, q;
        d = (dim == 0) ? 1 : longint'(dim);
        n = e * 4 + d;
        q = n / (2 * d);
        if ((n % (2 * d)) != 0 && n < 0) q -= 1;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        if (clip_on) begin
            if (q < 0) q = 0;
            if (q > 16384) q = 16384;
        end
        return q[15:0];
    endfunction

    task automatic predict_boxes(logic [9:0] col, logic [9:0] row);
        longint cx, cy, side;
        longint unsigned mn, mx;
        t_box b;
        cx = longint'((64'(col) * 256 + cen_off) * stp_x);
        cy = longint'((64'(row) * 256 + cen_off) * stp_y);
        for (int s = 0; s < N_SIZES; s++) begin
            mn = (min_tab >> (12 * s)) & 12'hFFF;
            mx = (max_tab >> (12 * s)) & 12'hFFF;
            for (int k = 0; k < 2; k++) begin
                side = (k == 0) ? longint'(mn << 12) : longint'(int_sqrt((mn * mx) << 24));
                b.xmin = to_norm(2 * cx - side, img_w);
                b.ymin = to_norm(2 * cy - side, img_h);
                b.xmax = to_norm(2 * cx + side, img_w);
                b.ymax = to_norm(2 * cy + side, img_h);
                b.slot = 3'(2 * s + k);
                b.last = (s == N_SIZES - 1) && (k == 1);
                pending_boxes = {pending_boxes, b};
            end
        end
    endtask

    // one write per call, the enable drops in a step of its own before the next write
    task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:  img_w = val[12:0];
            CFG_IMAGE_HEIGHT: img_h = val[12:0];
            CFG_STEP_X:       stp_x = val[15:0];
            CFG_STEP_Y:       stp_y = val[15:0];
            CFG_CELL_OFFSET:  cen_off = val[7:0];
            CFG_CLIP_ENABLE:  clip_on = val[0];
            CFG_MIN_TABLE:    min_tab = val[47:0];
            CFG_MAX_TABLE:    max_tab = val[47:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // drop tvalid, wait until every predicted box has left, then let the pipeline settle
    task automatic drain_boxes();
        s_axis_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // offer one cell; hold tvalid until it is taken, keep it high into the next cell
    task automatic send_cell(logic [9:0] col, logic [9:0] row, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 12) : 0;
        if (gaps && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_boxes(col, row);
    endtask

    task automatic random_config();
        write_reg(CFG_IMAGE_WIDTH, 48'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                              : $urandom_range(1, 4096)));
        write_reg(CFG_IMAGE_HEIGHT, 48'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                                               : $urandom_range(1, 4096)));
        write_reg(CFG_STEP_X, 48'($urandom_range(0, 65535)));
        write_reg(CFG_STEP_Y, 48'($urandom_range(0, 65535)));
        write_reg(CFG_CELL_OFFSET, 48'($urandom_range(0, 255)));
        write_reg(CFG_CLIP_ENABLE, 48'($urandom_range(0, 1)));
        write_reg(CFG_MIN_TABLE, 48'({$urandom(), $urandom()}));
        write_reg(CFG_MAX_TABLE, 48'({$urandom(), $urandom()}));
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (hold_off) begin
                stall = HOLD_LEN;
                hold_off = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Checker: compare each box transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_box exp_b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_boxes.size() == 0) begin
                $error("box transfer with no prediction waiting");
                failures++;
            end else begin
                exp_b = pending_boxes.pop_front();
                if (m_axis_tdata[15:0] !== exp_b.xmin) begin
                    $error("box_xmin exp %0d got %0d", exp_b.xmin, $signed(m_axis_tdata[15:0]));
                    failures++;
                end
                if (m_axis_tdata[31:16] !== exp_b.ymin) begin
                    $error("box_ymin exp %0d got %0d", exp_b.ymin, $signed(m_axis_tdata[31:16]));
                    failures++;
                end
                if (m_axis_tdata[47:32] !== exp_b.xmax) begin
                    $error("box_xmax exp %0d got %0d", exp_b.xmax, $signed(m_axis_tdata[47:32]));
                    failures++;
                end
                if (m_axis_tdata[63:48] !== exp_b.ymax) begin
                    $error("box_ymax exp %0d got %0d", exp_b.ymax, $signed(m_axis_tdata[63:48]));
                    failures++;
                end
                if (m_axis_tuser !== exp_b.slot) begin
                    $error("prior_slot exp %0d got %0d", exp_b.slot, m_axis_tuser);
                    failures++;
                end
                if (m_axis_tlast !== exp_b.last) begin
                    $error("last_prior exp %0d got %0d", exp_b.last, m_axis_tlast);
                    failures++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either stream.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    t_cell_row directed[$];

    task automatic add_row(logic [9:0] c, logic [9:0] r, bit t, t_box b);
        t_cell_row x;
        x.col = c; x.row = r; x.typed = t; x.box = b;
        directed = {directed, x};
    endtask

    // Stimulus
    initial begin
        t_box none;
        none = '0;
        shadow_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset: sizes 0, centre at 0.5*8 px = 4 px, 4/300 of 16384 -> 218.
        add_row(10'd0, 10'd0, 1, '{16'sd218, 16'sd218, 16'sd218, 16'sd218, 3'd0, 1'b0});
        add_row(10'd1023, 10'd1023, 0, none);
        add_row(10'd1023, 10'd0, 0, none);
        add_row(10'd0, 10'd1023, 0, none);
        add_row(10'h2AA, 10'h155, 0, none);
        add_row(10'h155, 10'h2AA, 0, none);
        foreach (directed[i]) begin
            if (directed[i].typed) begin
                predict_boxes(directed[i].col, directed[i].row);
                if (pending_boxes[pending_boxes.size() - 2] != directed[i].box) begin
                    $error("predictor disagrees with typed box on row %0d", i);
                    failures++;
                end
                void'(pending_boxes.pop_back());
                void'(pending_boxes.pop_back());
            end
            send_cell(directed[i].col, directed[i].row, 0);
        end
        drain_boxes();

        // Extremes: zero and maximum dims and steps, full sizes, clipping on.
        write_reg(CFG_IMAGE_WIDTH, 48'd0);
        write_reg(CFG_IMAGE_HEIGHT, 48'd8191);
        write_reg(CFG_STEP_X, 48'd0);
        write_reg(CFG_STEP_Y, 48'd65535);
        write_reg(CFG_CELL_OFFSET, 48'd255);
        write_reg(CFG_CLIP_ENABLE, 48'd1);
        write_reg(CFG_MIN_TABLE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_MAX_TABLE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_UNMAPPED, 48'd123);
        send_cell(10'd0, 10'd0, 0);
        send_cell(10'd1023, 10'd1023, 0);
        send_cell(10'd7, 10'd500, 0);
        drain_boxes();

        write_reg(CFG_IMAGE_WIDTH, 48'd4096);
        write_reg(CFG_IMAGE_HEIGHT, 48'd1);
        write_reg(CFG_STEP_X, 48'd1);
        write_reg(CFG_STEP_Y, 48'd0);
        write_reg(CFG_CELL_OFFSET, 48'd0);
        write_reg(CFG_CLIP_ENABLE, 48'd0);
        write_reg(CFG_MIN_TABLE, 48'h000_000_000_100);
        write_reg(CFG_MAX_TABLE, 48'h000_000_000_000);
        send_cell(10'd0, 10'd0, 0);
        send_cell(10'd1023, 10'd1, 0);
        send_cell(10'd512, 10'd512, 0);
        drain_boxes();

        // Random phases; realistic settings in the first phase, random settings in the rest.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_IMAGE_WIDTH, 48'd300);
                write_reg(CFG_IMAGE_HEIGHT, 48'd300);
                write_reg(CFG_STEP_X, 48'd128);
                write_reg(CFG_STEP_Y, 48'd128);
                write_reg(CFG_CELL_OFFSET, 48'd128);
                write_reg(CFG_MIN_TABLE, 48'd30);
                write_reg(CFG_MAX_TABLE, 48'd60);
            end else begin
                random_config();
            end
            if (ph == 2) hold_off = 1;
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if (ph == 0)
                    send_cell(10'($urandom_range(0, 40)), 10'($urandom_range(0, 40)), 1);
                else
                    send_cell(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                              ph != 2);
            end
            drain_boxes();
        end

        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
